// ===== src/smtprc_pkg.sv =====
package smtprc_pkg;

    // ASCII codes used by the line checks
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;

    // Reply code limits
    localparam logic [9:0] CODE_MIN     = 10'd100;
    localparam logic [9:0] CODE_MAX     = 10'd559;
    localparam logic [9:0] CODE_OK_LAST = 10'd399;

    // Line position saturates here
    localparam logic [2:0] POS_MAX = 3'd7;

    // Error classes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_UNAVAILABLE = 4'd1;
    localparam logic [3:0] ERR_SERVER_INT  = 4'd2;
    localparam logic [3:0] ERR_STORAGE     = 4'd3;
    localparam logic [3:0] ERR_CMD_REJECT  = 4'd4;
    localparam logic [3:0] ERR_NOT_EXIST   = 4'd5;
    localparam logic [3:0] ERR_UPGRADE     = 4'd6;
    localparam logic [3:0] ERR_AUTH        = 4'd7;
    localparam logic [3:0] ERR_OTHER       = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_line;
        logic       start_response;
    } t_in_word;

    typedef struct packed {
        logic [9:0] reply_code;
        logic       is_valid;
        logic       is_well_formed;
        logic       is_complete;
        logic [3:0] error_class;
    } t_out_word;

    // Response state carried across lines
    typedef struct packed {
        logic [9:0] code;
        logic       valid;
        logic       well_formed;
        logic       last_line;
    } t_resp_state;

    typedef logic [3:0][7:0] t_head;

    localparam t_resp_state RESP_RESET = '{
        code: 10'd0, valid: 1'b1, well_formed: 1'b1, last_line: 1'b0
    };

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHR_ZERO) && (b <= CHR_NINE);
    endfunction

    // Map a stored reply code to its error class
    function automatic logic [3:0] map_error(input logic [9:0] c);
        logic [3:0] cls;
        unique case (c)
            10'd421, 10'd454, 10'd554:           cls = ERR_UNAVAILABLE;
            10'd451:                             cls = ERR_SERVER_INT;
            10'd452, 10'd552:                    cls = ERR_STORAGE;
            10'd500, 10'd501, 10'd502,
            10'd503, 10'd504:                    cls = ERR_CMD_REJECT;
            10'd450, 10'd550, 10'd551, 10'd553:  cls = ERR_NOT_EXIST;
            10'd530, 10'd534, 10'd538:           cls = ERR_UPGRADE;
            10'd432:                             cls = ERR_AUTH;
            default: begin
                if ((c >= CODE_MIN) && (c <= CODE_OK_LAST)) cls = ERR_NONE;
                else                                        cls = ERR_OTHER;
            end
        endcase
        return cls;
    endfunction

endpackage

// ===== src/smtprc_chan_if.sv =====
interface smtprc_chan_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/smtprc_line_chk.sv =====
module smtprc_line_chk
    import smtprc_pkg::*;
(
    input  t_resp_state i_state,
    input  t_head       i_head,
    input  logic [2:0]  i_count,
    input  logic [7:0]  i_cur_byte,
    input  logic [7:0]  i_prev_byte,
    output t_resp_state o_state
);

    logic       w_strip;
    logic       w_len_ge3;
    logic       w_len_eq3;
    logic       w_digits;
    logic [9:0] w_code;

    // Trailing CR LF removal shortens the line by two
    assign w_strip   = (i_count >= 3'd2) && (i_cur_byte == CHR_LF) &&
                       (i_prev_byte == CHR_CR);
    assign w_len_ge3 = w_strip ? (i_count >= 3'd5) : (i_count >= 3'd3);
    assign w_len_eq3 = w_strip ? (i_count == 3'd5) : (i_count == 3'd3);

    // Three-digit code from the head of the line
    assign w_digits = is_digit(i_head[0]) && is_digit(i_head[1]) &&
                      is_digit(i_head[2]);
    assign w_code   = 10'({6'd0, i_head[0][3:0]} * 10'd100)
                    + 10'({6'd0, i_head[1][3:0]} * 10'd10)
                    + {6'd0, i_head[2][3:0]};

    always_comb begin
        o_state = i_state;
        if (i_state.well_formed) begin
            if (i_state.last_line) o_state.valid = 1'b0;
            priority if (!w_len_ge3 || !w_digits || (w_code < CODE_MIN)) begin
                o_state.valid       = 1'b0;
                o_state.well_formed = 1'b0;
            end else if (w_code > CODE_MAX) begin
                o_state.valid = 1'b0;
            end else if ((i_state.code != 10'd0) && (w_code != i_state.code)) begin
                o_state.valid = 1'b0;
            end else begin
                o_state.code = w_code;
                priority if (w_len_eq3 || (i_head[3] == CHR_SPACE)) begin
                    o_state.last_line = 1'b1;
                end else if (i_head[3] != CHR_HYPHEN) begin
                    o_state.valid       = 1'b0;
                    o_state.well_formed = 1'b0;
                end else begin
                    o_state.last_line = i_state.last_line;
                end
            end
        end
    end

endmodule

// ===== src/smtp_reply_line_checker.sv =====
// The response state loop is one register deep; a line's last byte passes the input
// register, then the result register. One byte word per cycle, unless a line end is blocked.
// A stalled output holds one result while the next byte is still taken.
// Reset (i_rst_n low, synchronous): code 0, valid and well-formed set,
// last-line clear, line position and byte history cleared, no words pending.
module smtp_reply_line_checker
    import smtprc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    smtprc_chan_if.sink   i_in,
    smtprc_chan_if.source o_out
);

    t_in_word    r_in;
    logic        r_in_valid;
    t_out_word   r_out;
    logic        r_out_valid;

    t_resp_state r_state;
    logic [2:0]  r_pos;
    t_head       r_head;
    logic [7:0]  r_prev;

    logic        w_out_free;
    logic        w_proc;
    logic        w_in_fire;
    t_resp_state w_state_eff;
    logic [2:0]  w_pos_eff;
    logic [7:0]  w_prev_eff;
    logic [2:0]  w_count;
    t_head       w_head;
    t_resp_state n_state;

    // Handshake: the input register moves on unless it holds a line end and a result is blocked
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_proc      = r_in_valid && (!r_in.end_of_line || w_out_free);
    assign i_in.ready  = !r_in_valid || w_proc;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // State as seen by this word, after an optional response restart
    assign w_state_eff = r_in.start_response ? RESP_RESET : r_state;
    assign w_pos_eff   = r_in.start_response ? 3'd0 : r_pos;
    assign w_prev_eff  = r_in.start_response ? 8'd0 : r_prev;
    assign w_count     = (w_pos_eff == POS_MAX) ? POS_MAX : w_pos_eff + 3'd1;

    // Head bytes with the current byte written in place
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (w_pos_eff == 3'(i))           w_head[i] = r_in.data_byte;
            else if (r_in.start_response)     w_head[i] = 8'd0;
            else                              w_head[i] = r_head[i];
        end
    end

    smtprc_line_chk u_line_chk (
        .i_state     (w_state_eff),
        .i_head      (w_head),
        .i_count     (w_count),
        .i_cur_byte  (r_in.data_byte),
        .i_prev_byte (w_prev_eff),
        .o_state     (n_state)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_fire) r_in <= i_in.payload;
    end

    // Response and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RESP_RESET;
            r_pos   <= 3'd0;
            r_head  <= '0;
            r_prev  <= 8'd0;
        end else if (w_proc) begin
            if (r_in.end_of_line) begin
                r_state <= n_state;
                r_pos   <= 3'd0;
                r_head  <= '0;
                r_prev  <= 8'd0;
            end else begin
                r_state <= w_state_eff;
                r_pos   <= w_count;
                r_head  <= w_head;
                r_prev  <= r_in.data_byte;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in.end_of_line) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_proc && r_in.end_of_line) begin
            r_out.reply_code     <= n_state.code;
            r_out.is_valid       <= n_state.valid;
            r_out.is_well_formed <= n_state.well_formed;
            r_out.is_complete    <= n_state.last_line;
            r_out.error_class    <= map_error(n_state.code);
        end
    end

`ifndef ASSERT_OFF
    // Stored code is either unset or a legal reply code
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.code == 10'd0) ||
        ((r_state.code >= CODE_MIN) && (r_state.code <= CODE_MAX)))
        else $error("stored reply code out of range");

    // Last line can only be flagged once a code was stored
    a_last_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.last_line |-> (r_state.code != 10'd0))
        else $error("last line flagged without a code");

    // Malformed response stays malformed until a restart
    a_wf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_state.well_formed && !(w_proc && r_in.start_response))
        |=> !r_state.well_formed)
        else $error("well-formed flag recovered without restart");

    // A processed line end always yields a result word
    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.end_of_line) |=> r_out_valid)
        else $error("line end produced no result word");
`endif

endmodule

// ===== tb/smtp_reply_line_checker_tb.sv =====
`timescale 1ns / 100ps

module smtp_reply_line_checker_tb;
    import smtprc_pkg::*;

    logic i_clk;
    logic i_rst_n;

    smtprc_chan_if #(.T_PAYLOAD(t_in_word))  in_ch  ();
    smtprc_chan_if #(.T_PAYLOAD(t_out_word)) out_ch ();

    smtp_reply_line_checker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted response state and current line history
    logic [9:0] resp_code;
    logic       resp_valid;
    logic       resp_wf;
    logic       resp_last;
    logic [2:0] line_pos;
    logic [7:0] line_head [4];
    logic [7:0] prev_byte;

    t_out_word  reply_expect_q [$];
    logic [7:0] line_buf [$];

    int words_sent     = 0;
    int replies_seen   = 0;
    int responses_sent = 0;
    int mismatches     = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int sink_hold      = 0;

    // Codes with their own error class, plus the range edges and some plain success codes
    int notable_codes [26] = '{100, 199, 250, 354, 399, 400, 421, 432, 450, 451,
                               452, 454, 500, 501, 502, 503, 504, 530, 534, 538,
                               550, 551, 552, 553, 554, 559};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #(5_000_000);
        $display("smtp_reply_line_checker: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Line and response tracking
    // ---------------------------------------------------------------
    function automatic void clear_line();
        line_pos  = 3'd0;
        prev_byte = 8'd0;
        for (int k = 0; k < 4; k++) line_head[k] = 8'd0;
    endfunction

    function automatic void clear_resp();
        resp_code  = 10'd0;
        resp_valid = 1'b1;
        resp_wf    = 1'b1;
        resp_last  = 1'b0;
        clear_line();
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= CHR_ZERO) && (b <= CHR_NINE);
    endfunction

    function automatic logic [3:0] class_of(input logic [9:0] c);
        logic [3:0] k;
        // fallback: plain success range vs. anything else
        k = ((c >= CODE_MIN) && (c <= CODE_OK_LAST)) ? ERR_NONE : ERR_OTHER;
        case (c)
            10'd421, 10'd454, 10'd554:          k = ERR_UNAVAILABLE;
            10'd451:                            k = ERR_SERVER_INT;
            10'd452, 10'd552:                   k = ERR_STORAGE;
            10'd450, 10'd550, 10'd551, 10'd553: k = ERR_NOT_EXIST;
            10'd530, 10'd534, 10'd538:          k = ERR_UPGRADE;
            10'd432:                            k = ERR_AUTH;
            default: begin
                if ((c >= 10'd500) && (c <= 10'd504)) k = ERR_CMD_REJECT;
            end
        endcase
        return k;
    endfunction

    // Judge a finished line of cnt bytes whose last byte is cur
    function automatic void judge_line(input int cnt, input logic [7:0] cur);
        int len;
        int code;
        if (!resp_wf) return;
        if (resp_last) resp_valid = 1'b0;
        len = cnt;
        if ((cnt >= 2) && (cur == CHR_LF) && (prev_byte == CHR_CR)) len = cnt - 2;
        if ((len < 3) || !is_dec(line_head[0]) || !is_dec(line_head[1])
                || !is_dec(line_head[2])) begin
            resp_valid = 1'b0;
            resp_wf    = 1'b0;
            return;
        end
        code = 100 * (int'(line_head[0]) - int'(CHR_ZERO))
             + 10  * (int'(line_head[1]) - int'(CHR_ZERO))
             +       (int'(line_head[2]) - int'(CHR_ZERO));
        if (code < int'(CODE_MIN)) begin
            resp_valid = 1'b0;
            resp_wf    = 1'b0;
        end else if (code > int'(CODE_MAX)) begin
            resp_valid = 1'b0;
        end else if ((resp_code != 10'd0) && (code != int'(resp_code))) begin
            resp_valid = 1'b0;
        end else begin
            resp_code = 10'(code);
            if ((len == 3) || (line_head[3] == CHR_SPACE)) begin
                resp_last = 1'b1;
            end else if (line_head[3] != CHR_HYPHEN) begin
                resp_valid = 1'b0;
                resp_wf    = 1'b0;
            end
        end
    endfunction

    // Advance the tracker by one accepted byte word
    function automatic void track_word(input t_in_word w);
        int        cnt;
        t_out_word r;
        if (w.start_response) clear_resp();
        if (line_pos < 3'd4) line_head[line_pos[1:0]] = w.data_byte;
        cnt = (line_pos < POS_MAX) ? int'(line_pos) + 1 : int'(POS_MAX);
        if (!w.end_of_line) begin
            line_pos  = 3'(cnt);
            prev_byte = w.data_byte;
            return;
        end
        judge_line(cnt, w.data_byte);
        clear_line();
        r.reply_code     = resp_code;
        r.is_valid       = resp_valid;
        r.is_well_formed = resp_wf;
        r.is_complete    = resp_last;
        r.error_class    = class_of(resp_code);
        reply_expect_q.insert(reply_expect_q.size(), r);
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_reply
        t_out_word got;
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (reply_expect_q.size() == 0) begin
                report_mismatch($sformatf("reply word %h with none expected", got));
            end else begin
                want = reply_expect_q.pop_front();
                replies_seen++;
                if (got.reply_code !== want.reply_code)
                    report_mismatch($sformatf("reply %0d: reply_code %0d, want %0d",
                        replies_seen, got.reply_code, want.reply_code));
                if (got.is_valid !== want.is_valid)
                    report_mismatch($sformatf("reply %0d: is_valid %b, want %b",
                        replies_seen, got.is_valid, want.is_valid));
                if (got.is_well_formed !== want.is_well_formed)
                    report_mismatch($sformatf("reply %0d: is_well_formed %b, want %b",
                        replies_seen, got.is_well_formed, want.is_well_formed));
                if (got.is_complete !== want.is_complete)
                    report_mismatch($sformatf("reply %0d: is_complete %b, want %b",
                        replies_seen, got.is_complete, want.is_complete));
                if (got.error_class !== want.error_class)
                    report_mismatch($sformatf("reply %0d: error_class %0d, want %0d",
                        replies_seen, got.error_class, want.error_class));
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int gap_length();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 24);
    endfunction

    // Output stalls: random holds of random length
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            out_ch.ready <= 1'b0;
            sink_hold    <= sink_hold - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < sink_stall_pct) sink_hold <= gap_length();
        end
    end

    // Send one byte word; entered and left at a falling edge
    task automatic send_word(input logic [7:0] b, input logic eol, input logic start);
        t_in_word w;
        int       gap;
        w.data_byte      = b;
        w.end_of_line    = eol;
        w.start_response = start;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? gap_length() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        track_word(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line(input bit fresh);
        foreach (line_buf[k])
            send_word(line_buf[k], k == line_buf.size() - 1, fresh && (k == 0));
    endtask

    task automatic add_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    task automatic load_line(input string s, input bit crlf);
        line_buf.delete();
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
        if (crlf) begin
            add_byte(CHR_CR);
            add_byte(CHR_LF);
        end
    endtask

    task automatic push_code(input int c);
        add_byte(8'(int'(CHR_ZERO) + c / 100));
        add_byte(8'(int'(CHR_ZERO) + (c / 10) % 10));
        add_byte(8'(int'(CHR_ZERO) + c % 10));
    endtask

    // One response of up to four lines, optionally with one broken line that may be an extra one after them
    task automatic send_response(input bit fresh, input bit flawed);
        int         n_lines;
        int         code;
        int         flaw_line;
        int         flaw_kind;
        int         last_ln;
        int         tlen;
        int         keep;
        logic [7:0] sep;
        n_lines   = $urandom_range(1, 4);
        code      = $urandom_range(0, 1) ? notable_codes[$urandom_range(0, 25)]
                                         : $urandom_range(100, 559);
        flaw_line = flawed ? $urandom_range(0, n_lines) : -1;
        flaw_kind = $urandom_range(0, 4);
        // a flaw on index n_lines means an extra line after the final one
        last_ln   = (flaw_line == n_lines) ? n_lines : n_lines - 1;
        responses_sent++;
        for (int ln = 0; ln <= last_ln; ln++) begin
            line_buf.delete();
            if ((ln == flaw_line) && (flaw_kind == 0))      push_code($urandom_range(0, 999));
            else if ((ln == flaw_line) && (flaw_kind == 4)) push_code($urandom_range(560, 999));
            else                                            push_code(code);
            tlen = $urandom_range(0, 5);
            sep  = (ln < n_lines - 1) ? CHR_HYPHEN : CHR_SPACE;
            if ((ln == flaw_line) && (flaw_kind == 1)) sep = 8'($urandom_range(0, 255));
            if ((sep != CHR_SPACE) || (tlen > 0) || $urandom_range(0, 1))
                add_byte(sep);
            repeat (tlen) add_byte(8'($urandom_range(0, 255)));
            if ((ln == flaw_line) && (flaw_kind == 2))
                line_buf[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
            if ((ln == flaw_line) && (flaw_kind == 3)) begin
                keep = $urandom_range(1, 2);
                while (line_buf.size() > keep) void'(line_buf.pop_back());
            end
            if ($urandom_range(0, 1)) begin
                add_byte(CHR_CR);
                add_byte(CHR_LF);
            end
            send_line(fresh && (ln == 0));
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_special_cases();
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        // bare code closes the response
        load_line("250", 0);      send_line(1);
        // line after the final line, with a different code
        load_line("251", 0);      send_line(0);
        // code below range breaks the syntax
        load_line("099", 0);      send_line(1);
        // ignored line once malformed; too short as well
        line_buf.delete();
        add_byte(8'hFF);
        send_line(0);
        // code above range: invalid but still well formed
        load_line("600", 0);      send_line(1);
        // CR LF stripped, continuation then final line
        load_line("421-", 1);     send_line(1);
        load_line("421 ", 0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CHR_CR);
        add_byte(CHR_LF);
        send_line(0);
        // too short once CR LF is dropped
        load_line("25", 1);       send_line(1);
        // start of response in mid-line restarts the line
        send_word("9", 1'b0, 1'b1);
        send_word("5", 1'b0, 1'b1);
        send_word("5", 1'b0, 1'b0);
        send_word("4", 1'b1, 1'b0);
    endtask

    task automatic test_random_responses(input int n_words);
        int base;
        base = words_sent;
        while (words_sent - base < n_words) begin
            if ($urandom_range(0, 15) == 0) begin
                src_gap_pct    = $urandom_range(0, 2) * 30;
                sink_stall_pct = $urandom_range(0, 2) * 25;
            end
            send_response($urandom_range(0, 9) != 0, $urandom_range(0, 99) < 30);
        end
    endtask

    task automatic test_noise(input int n_words);
        int base;
        base           = words_sent;
        src_gap_pct    = 25;
        sink_stall_pct = 25;
        while (words_sent - base < n_words) begin
            if ($urandom_range(0, 3) == 0)
                send_response($urandom_range(0, 1), 1'b1);
            else
                send_word(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                          $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic test_back_to_back(input int n_words);
        int base;
        base           = words_sent;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        while (words_sent - base < n_words)
            send_response(1'b1, $urandom_range(0, 3) == 0);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int waited;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        clear_resp();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_special_cases();
        test_random_responses(850);
        test_noise(250);
        test_back_to_back(170);
        in_ch.valid <= 1'b0;

        // drain outstanding replies, then allow for pipeline latency
        waited = 0;
        while ((reply_expect_q.size() != 0) && (waited < 2000)) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (reply_expect_q.size() != 0)
            report_mismatch($sformatf("%0d reply words never arrived", reply_expect_q.size()));

        $display("run covered %0d byte words, %0d generated responses plus noise lines",
                 words_sent, responses_sent);
        $display("%0d reply words checked, %0d field mismatches", replies_seen, mismatches);
        if (mismatches == 0) begin
            $display("smtp_reply_line_checker: match");
        end else begin
            $display("smtp_reply_line_checker: mismatch");
        end
        $finish;
    end

endmodule
